>>> rtl/transform_matrix_compose_unit_macros.svh
// assertion macros for the transform matrix compose unit
// used by the rtl files that carry concurrent checks
`ifndef TRANSFORM_MATRIX_COMPOSE_UNIT_MACROS_SVH
`define TRANSFORM_MATRIX_COMPOSE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define TMC_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define TMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define TMC_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TMC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/tmc_pkg.sv
// shared types, opcodes and constants of the transform matrix compose unit
// no dependencies
package tmc_pkg;
  localparam int CORDIC_STEPS = 16;
  localparam int FRAC_BITS = 16;

  localparam logic [3:0] OP_IDENTITY = 4'd0;
  localparam logic [3:0] OP_SET_T = 4'd1;
  localparam logic [3:0] OP_SET_S = 4'd2;
  localparam logic [3:0] OP_SET_R = 4'd3;
  localparam logic [3:0] OP_FRONT_T = 4'd4;
  localparam logic [3:0] OP_FRONT_S = 4'd5;
  localparam logic [3:0] OP_FRONT_R = 4'd6;
  localparam logic [3:0] OP_BACK_T = 4'd7;
  localparam logic [3:0] OP_BACK_S = 4'd8;
  localparam logic [3:0] OP_BACK_R = 4'd9;

  localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
  localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;
  localparam logic signed [35:0] TWO_PI_Q30 = 36'sd6746518852;
  localparam logic signed [35:0] GAIN_Q30 = 36'sh026DD3B6A;

  // alu operation code
  typedef enum logic [1:0] {
    MOP_MUL = 2'd0,
    MOP_ADD = 2'd1,
    MOP_SUB = 2'd2
  } mop_t;

  function automatic logic [29:0] arctan(input logic [4:0] i);
    case (i)
      5'd0: arctan = 30'h3243F6A8;
      5'd1: arctan = 30'h1DAC6705;
      5'd2: arctan = 30'h0FADBAFC;
      5'd3: arctan = 30'h07F56EA6;
      5'd4: arctan = 30'h03FEAB76;
      5'd5: arctan = 30'h01FFD55B;
      5'd6: arctan = 30'h00FFFAAA;
      5'd7: arctan = 30'h007FFF55;
      5'd8: arctan = 30'h003FFFEA;
      5'd9: arctan = 30'h001FFFFD;
      5'd10: arctan = 30'h000FFFFF;
      5'd11: arctan = 30'h0007FFFF;
      5'd12: arctan = 30'h0003FFFF;
      5'd13: arctan = 30'h0001FFFF;
      5'd14: arctan = 30'h0000FFFF;
      5'd15: arctan = 30'h00007FFF;
      5'd16: arctan = 30'h00003FFF;
      5'd17: arctan = 30'h00001FFF;
      5'd18: arctan = 30'h00000FFF;
      5'd19: arctan = 30'h000007FF;
      5'd20: arctan = 30'h000003FF;
      5'd21: arctan = 30'h000001FF;
      5'd22: arctan = 30'h000000FF;
      5'd23: arctan = 30'h0000007F;
      5'd24: arctan = 30'h0000003F;
      5'd25: arctan = 30'h0000001F;
      5'd26: arctan = 30'h0000000F;
      5'd27: arctan = 30'h00000008;
      5'd28: arctan = 30'h00000004;
      5'd29: arctan = 30'h00000002;
      default: arctan = 30'h0;
    endcase
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) sat32 = 32'sh7FFFFFFF;
    else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
    else sat32 = v[31:0];
  endfunction
endpackage

>>> rtl/tmc_cordic.sv
// iterative cordic: one micro-rotation per cycle, gives sin and cos
// depends on tmc_pkg
module tmc_cordic #(
  parameter int CORDIC_STEPS = tmc_pkg::CORDIC_STEPS
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic signed [18:0] angle,
  output logic done,
  output logic signed [31:0] sin_val,
  output logic signed [31:0] cos_val
);
  localparam int STEPS = (CORDIC_STEPS > 30) ? 30 : CORDIC_STEPS;
  localparam int SH = 30 - tmc_pkg::FRAC_BITS;

  typedef enum logic [3:0] {
    C_IDLE = 4'b0001, C_REDUCE = 4'b0010, C_ITER = 4'b0100, C_OUT = 4'b1000
  } cst_t;

  cst_t state;
  logic signed [35:0] x, y, z;
  logic neg;
  logic [4:0] step;
  logic signed [35:0] xs, ys, zr, zm;
  logic signed [35:0] xf, yf;

  assign xs = x >>> step;
  assign ys = y >>> step;
  // single remainder correction: a 19-bit Q3.16 angle lies within plus or minus 4 rad
  always_comb begin
    zm = z;
    if (zm > tmc_pkg::PI_Q30) zm = zm - tmc_pkg::TWO_PI_Q30;
    if (zm < -tmc_pkg::PI_Q30) zm = zm + tmc_pkg::TWO_PI_Q30;
    zr = zm;
  end
  assign xf = neg ? -x : x;
  assign yf = neg ? -y : y;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      done <= 1'b0;
    end else begin
      done <= (state == C_OUT);
      unique case (state)
        C_IDLE: begin
          if (start) begin
            z <= 36'(angle) <<< SH;
            x <= tmc_pkg::GAIN_Q30;
            y <= '0;
            step <= '0;
            state <= C_REDUCE;
          end
        end
        C_REDUCE: begin
          if (zr > tmc_pkg::HALF_PI_Q30) begin
            z <= zr - tmc_pkg::PI_Q30;
            neg <= 1'b1;
          end else if (zr < -tmc_pkg::HALF_PI_Q30) begin
            z <= zr + tmc_pkg::PI_Q30;
            neg <= 1'b1;
          end else begin
            z <= zr;
            neg <= 1'b0;
          end
          state <= C_ITER;
        end
        C_ITER: begin
          if (!z[35]) begin
            x <= x - ys;
            y <= y + xs;
            z <= z - 36'(tmc_pkg::arctan(step));
          end else begin
            x <= x + ys;
            y <= y - xs;
            z <= z + 36'(tmc_pkg::arctan(step));
          end
          step <= step + 5'd1;
          if (step == 5'(STEPS - 1)) state <= C_OUT;
        end
        C_OUT: begin
          cos_val <= tmc_pkg::sat32(64'((xf + (36'sd1 <<< (SH - 1))) >>> SH));
          sin_val <= tmc_pkg::sat32(64'((yf + (36'sd1 <<< (SH - 1))) >>> SH));
          state <= C_IDLE;
        end
        default: state <= C_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/tmc_alu.sv
// shared fixed-point unit: shifted multiply with saturation, saturated add/sub
// depends on tmc_pkg
module tmc_alu #(
  parameter int FRAC_BITS = tmc_pkg::FRAC_BITS
) (
  input  logic clk,
  input  tmc_pkg::mop_t op,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [63:0] prod_shifted,
  output logic signed [31:0] result
);
  logic signed [63:0] p;
  logic signed [63:0] w;
  assign p = (64'(a) * 64'(b)) >>> FRAC_BITS;
  always_comb begin
    case (op)
      tmc_pkg::MOP_ADD: w = 64'(a) + 64'(b);
      tmc_pkg::MOP_SUB: w = 64'(a) - 64'(b);
      default: w = p;
    endcase
  end
  always_ff @(posedge clk) begin
    prod_shifted <= p;
    result <= tmc_pkg::sat32(w);
  end
endmodule

>>> rtl/transform_matrix_compose_unit.sv
// top level of the transform matrix compose unit: sequencer, matrices, output stage
// depends on tmc_pkg, tmc_alu, tmc_cordic and the assertion macro header
// An item is accepted only while the block is idle; each item then passes through
// the accept, its build and the output of its 16 elements, where the first element
// is loaded before the 16 transfers. Identity and unused opcodes go straight to the
// output; set translate or scale build the matrix directly, and set rotate first runs
// the cordic and then 27 alu operations, each issued in phase 0 and captured in
// phase 1, on the one shared multiplier. A front or back compose adds 64
// multiply-accumulates through that same multiplier, one product issued per cycle
// and a wait state after each element. The shared multiplier sets the rate.
// Results leave through a register; the output holds while tready is low.
`include "transform_matrix_compose_unit_macros.svh"
module transform_matrix_compose_unit #(
  parameter int CORDIC_STEPS = tmc_pkg::CORDIC_STEPS
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // opcode[3:0], x_operand[35:4], y_operand[67:36], z_operand[99:68],
  // angle[118:100], zeros to 119
  input  logic [119:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // element_index[3:0], element_value[35:4], zeros to 39
  output logic [39:0] m_tdata,
  output logic m_tlast
);
  localparam logic signed [31:0] ONE = 32'sd1 <<< tmc_pkg::FRAC_BITS;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_BUILD = 8'b00000010, S_CORD = 8'b00000100,
    S_ROT = 8'b00001000, S_MAC = 8'b00010000, S_MACW = 8'b00100000,
    S_COPY = 8'b01000000, S_OUT = 8'b10000000
  } st_t;

  st_t state;
  logic [3:0] op;
  logic signed [31:0] ox, oy, oz;
  logic signed [18:0] oang;
  logic signed [31:0] cur [16];
  logic signed [31:0] opm [16];
  logic signed [31:0] opm_init [16];
  logic signed [31:0] tmp [16];
  // rotation scratch registers
  logic signed [31:0] rv [20];
  logic [4:0] rstep;
  logic [4:0] kcnt;
  logic [3:0] elem;
  logic [1:0] kk;
  logic signed [63:0] acc;
  logic back;

  tmc_pkg::mop_t aop;
  logic signed [31:0] aa, ab, ares;
  logic signed [63:0] aprod;
  logic cstart, cdone;
  logic signed [31:0] csin, ccos;

  tmc_alu #(.FRAC_BITS(tmc_pkg::FRAC_BITS)) u_alu (
    .clk(clk), .op(aop), .a(aa), .b(ab), .prod_shifted(aprod), .result(ares));

  tmc_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk(clk), .rst(rst), .start(cstart), .angle(oang), .done(cdone),
    .sin_val(csin), .cos_val(ccos));

  // rotation program: rv index map
  // 0 s,1 c,2 ic,3 x2,4 y2,5 z2,6 icx,7 icy,8 xs,9 ys,10 zs,11 cx2,12 cy2,13 cz2,
  // 14 icxy,15 icxz,16 icyz,17 t0,18 t1,19 t2
  logic [4:0] dst;
  always_comb begin
    aop = tmc_pkg::MOP_MUL; aa = '0; ab = '0; dst = 5'd0;
    if (state == S_MAC || state == S_MACW) begin
      // element = col*4+row; term kk
      if (back) begin
        aa = cur[{elem[3:2], kk}];
        ab = opm[{kk, elem[1:0]}];
      end else begin
        aa = opm[{elem[3:2], kk}];
        ab = cur[{kk, elem[1:0]}];
      end
    end else begin
      case (rstep)
        5'd0: begin aop = tmc_pkg::MOP_SUB; aa = ONE; ab = rv[1]; dst = 5'd2; end
        5'd1: begin aa = ox; ab = ox; dst = 5'd3; end
        5'd2: begin aa = oy; ab = oy; dst = 5'd4; end
        5'd3: begin aa = oz; ab = oz; dst = 5'd5; end
        5'd4: begin aa = rv[2]; ab = ox; dst = 5'd6; end
        5'd5: begin aa = rv[2]; ab = oy; dst = 5'd7; end
        5'd6: begin aa = ox; ab = rv[0]; dst = 5'd8; end
        5'd7: begin aa = oy; ab = rv[0]; dst = 5'd9; end
        5'd8: begin aa = oz; ab = rv[0]; dst = 5'd10; end
        5'd9: begin aa = rv[1]; ab = rv[3]; dst = 5'd11; end
        5'd10: begin aa = rv[1]; ab = rv[4]; dst = 5'd12; end
        5'd11: begin aa = rv[1]; ab = rv[5]; dst = 5'd13; end
        5'd12: begin aa = rv[6]; ab = oy; dst = 5'd14; end
        5'd13: begin aa = rv[6]; ab = oz; dst = 5'd15; end
        5'd14: begin aa = rv[7]; ab = oz; dst = 5'd16; end
        5'd15: begin aop = tmc_pkg::MOP_ADD; aa = rv[3]; ab = rv[12]; dst = 5'd17; end
        5'd16: begin aop = tmc_pkg::MOP_ADD; aa = rv[11]; ab = rv[4]; dst = 5'd18; end
        5'd17: begin aop = tmc_pkg::MOP_ADD; aa = rv[11]; ab = rv[12]; dst = 5'd19; end
        5'd18: begin aop = tmc_pkg::MOP_ADD; aa = rv[17]; ab = rv[13]; end
        5'd19: begin aop = tmc_pkg::MOP_ADD; aa = rv[18]; ab = rv[13]; end
        5'd20: begin aop = tmc_pkg::MOP_ADD; aa = rv[19]; ab = rv[5]; end
        5'd21: begin aop = tmc_pkg::MOP_SUB; aa = rv[14]; ab = rv[10]; end
        5'd22: begin aop = tmc_pkg::MOP_ADD; aa = rv[15]; ab = rv[9]; end
        5'd23: begin aop = tmc_pkg::MOP_ADD; aa = rv[14]; ab = rv[10]; end
        5'd24: begin aop = tmc_pkg::MOP_SUB; aa = rv[16]; ab = rv[8]; end
        5'd25: begin aop = tmc_pkg::MOP_SUB; aa = rv[15]; ab = rv[9]; end
        5'd26: begin aop = tmc_pkg::MOP_ADD; aa = rv[16]; ab = rv[8]; end
        default: ;
      endcase
    end
  end

  // opm destination of the final rotation sums
  logic [3:0] odst;
  always_comb begin
    case (rstep)
      5'd18: odst = 4'd0;
      5'd19: odst = 4'd5;
      5'd20: odst = 4'd10;
      5'd21: odst = 4'd1;
      5'd22: odst = 4'd2;
      5'd23: odst = 4'd4;
      5'd24: odst = 4'd6;
      5'd25: odst = 4'd8;
      default: odst = 4'd9;
    endcase
  end

  logic rphase;
  logic [3:0] kind_sel;
  logic [3:0] oidx;
  assign s_tready = (state == S_IDLE);
  assign cstart = (state == S_BUILD) && (kind_sel == 4'd2);

  always_comb begin
    case (op)
      tmc_pkg::OP_SET_T, tmc_pkg::OP_FRONT_T, tmc_pkg::OP_BACK_T: kind_sel = 4'd0;
      tmc_pkg::OP_SET_S, tmc_pkg::OP_FRONT_S, tmc_pkg::OP_BACK_S: kind_sel = 4'd1;
      tmc_pkg::OP_SET_R, tmc_pkg::OP_FRONT_R, tmc_pkg::OP_BACK_R: kind_sel = 4'd2;
      default: kind_sel = 4'd3;
    endcase
  end

  // operand matrix before the rotation terms are filled in
  always_comb begin
    for (int i = 0; i < 16; i++) opm_init[i] = '0;
    opm_init[15] = ONE;
    if (kind_sel == 4'd0) begin
      opm_init[0] = ONE; opm_init[5] = ONE; opm_init[10] = ONE;
      opm_init[12] = ox; opm_init[13] = oy; opm_init[14] = oz;
    end else if (kind_sel == 4'd1) begin
      opm_init[0] = ox; opm_init[5] = oy; opm_init[10] = oz;
    end
  end

  logic after_build_mac, after_build_set;
  assign after_build_set = (op == tmc_pkg::OP_SET_T) || (op == tmc_pkg::OP_SET_S) ||
                           (op == tmc_pkg::OP_SET_R);
  assign after_build_mac = !after_build_set;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      for (int i = 0; i < 16; i++)
        cur[i] <= (i % 5 == 0) ? ONE : 32'sd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            op <= s_tdata[3:0];
            ox <= s_tdata[35:4];
            oy <= s_tdata[67:36];
            oz <= s_tdata[99:68];
            oang <= s_tdata[118:100];
            back <= (s_tdata[3:0] >= tmc_pkg::OP_BACK_T);
            oidx <= '0;
            if (s_tdata[3:0] == tmc_pkg::OP_IDENTITY) begin
              for (int i = 0; i < 16; i++)
                cur[i] <= (i % 5 == 0) ? ONE : 32'sd0;
              state <= S_OUT;
            end else if (s_tdata[3:0] > tmc_pkg::OP_BACK_R) begin
              state <= S_OUT;
            end else begin
              state <= S_BUILD;
            end
          end
        end
        S_BUILD: begin
          for (int i = 0; i < 16; i++) opm[i] <= opm_init[i];
          rstep <= '0;
          rphase <= 1'b0;
          if (kind_sel == 4'd2) state <= S_CORD;
          else state <= after_build_mac ? S_MAC : S_COPY;
          elem <= '0; kk <= '0; acc <= '0; kcnt <= '0;
        end
        S_CORD: begin
          if (cdone) begin
            rv[0] <= csin; rv[1] <= ccos;
            state <= S_ROT;
          end
        end
        S_ROT: begin
          // issue in phase 0, alu result registered; capture in phase 1
          rphase <= !rphase;
          if (rphase) begin
            if (rstep < 5'd18) rv[dst] <= ares;
            else opm[odst] <= ares;
            rstep <= rstep + 5'd1;
            if (rstep == 5'd26) state <= after_build_mac ? S_MAC : S_COPY;
          end
        end
        S_MAC: begin
          // issue term kk; product registered for next cycle's accumulate
          if (kcnt != 5'd0) acc <= acc + aprod;
          kk <= kk + 2'd1;
          kcnt <= kcnt + 5'd1;
          if (kk == 2'd3) state <= S_MACW;
        end
        S_MACW: begin
          tmp[elem] <= tmc_pkg::sat32(acc + aprod);
          acc <= '0; kcnt <= '0; kk <= '0;
          elem <= elem + 4'd1;
          if (elem == 4'd15) state <= S_COPY;
          else state <= S_MAC;
        end
        S_COPY: begin
          for (int i = 0; i < 16; i++) cur[i] <= after_build_mac ? tmp[i] : opm[i];
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            if (m_tvalid && m_tlast) begin
              m_tvalid <= 1'b0;
              state <= S_IDLE;
            end else begin
              m_tvalid <= 1'b1;
              m_tdata <= {4'd0, cur[oidx], oidx};
              m_tlast <= (oidx == 4'd15);
              oidx <= oidx + 4'd1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `TMC_ASSERT_IMPL(a_ready_idle, clk, rst, s_tready, !m_tvalid)
  `TMC_ASSERT_NEXT(a_last_ends, clk, rst, m_tvalid && m_tready && m_tlast, !m_tvalid)
  `TMC_ASSERT_IMPL(a_last_idx, clk, rst, m_tvalid && m_tlast, m_tdata[3:0] == 4'd15)
  `TMC_ASSERT_NEXT(a_cord_done, clk, rst, cdone, state == S_ROT)
endmodule

>>> tb/tb_top.sv
// self-checking testbench of the transform matrix compose unit
// depends on tmc_pkg and the rtl top level; predicts all 16 elements per item
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ONE_Q = 1 << tmc_pkg::FRAC_BITS;
  localparam int HOLD_CYCLES = 1500;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [3:0] index;
    logic signed [31:0] value;
    logic last;
  } element_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [119:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic m_tlast;

  transform_matrix_compose_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic signed [31:0] model_matrix [16];
  element_t expected_elements [$];
  int mismatch_count = 0;
  int items_sent = 0;
  int elements_checked = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  longint cycle_count = 0;
  longint hold_until = 0;
  int idle_cycles = 0;

  localparam longint ATAN_Q30 [30] = '{
    64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
    64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
    64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
    64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
    64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
    64'h0000001F, 64'h0000000F, 64'h00000008, 64'h00000004, 64'h00000002
  };

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] qmul(input logic signed [31:0] a, b);
    return clamp32((longint'(a) * longint'(b)) >>> tmc_pkg::FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] qadd(input logic signed [31:0] a, b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic logic signed [31:0] qsub(input logic signed [31:0] a, b);
    return clamp32(longint'(a) - longint'(b));
  endfunction

  function automatic logic signed [31:0] q30_round(input longint v);
    int sh;
    sh = 30 - tmc_pkg::FRAC_BITS;
    return clamp32((v + (longint'(1) << (sh - 1))) >>> sh);
  endfunction

  task automatic cordic_sin_cos(input logic signed [18:0] ang,
                                output logic signed [31:0] s, output logic signed [31:0] c);
    longint z, x, y, nx;
    bit flip;
    int steps;
    z = longint'(ang) * (longint'(1) << (30 - tmc_pkg::FRAC_BITS));
    x = longint'(tmc_pkg::GAIN_Q30);
    y = 0;
    flip = 0;
    steps = (tmc_pkg::CORDIC_STEPS > 30) ? 30 : tmc_pkg::CORDIC_STEPS;
    z = z % longint'(tmc_pkg::TWO_PI_Q30);
    if (z > longint'(tmc_pkg::PI_Q30)) z -= longint'(tmc_pkg::TWO_PI_Q30);
    if (z < -longint'(tmc_pkg::PI_Q30)) z += longint'(tmc_pkg::TWO_PI_Q30);
    // fold into the right half plane, negate afterwards
    if (z > longint'(tmc_pkg::HALF_PI_Q30)) begin
      z -= longint'(tmc_pkg::PI_Q30);
      flip = 1;
    end else if (z < -longint'(tmc_pkg::HALF_PI_Q30)) begin
      z += longint'(tmc_pkg::PI_Q30);
      flip = 1;
    end
    for (int i = 0; i < steps; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ATAN_Q30[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ATAN_Q30[i];
      end
      x = nx;
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = q30_round(x);
    s = q30_round(y);
  endtask

  task automatic build_rotation(input logic signed [31:0] x, y, z,
                                input logic signed [18:0] ang,
                                output logic signed [31:0] m [16]);
    logic signed [31:0] s, c, ic, x2, y2, z2, icx, icy, xs, ys, zs, cx2, cy2, cz2;
    logic signed [31:0] icxy, icxz, icyz;
    cordic_sin_cos(ang, s, c);
    ic = qsub(ONE_Q, c);
    x2 = qmul(x, x);
    y2 = qmul(y, y);
    z2 = qmul(z, z);
    icx = qmul(ic, x);
    icy = qmul(ic, y);
    xs = qmul(x, s);
    ys = qmul(y, s);
    zs = qmul(z, s);
    cx2 = qmul(c, x2);
    cy2 = qmul(c, y2);
    cz2 = qmul(c, z2);
    icxy = qmul(icx, y);
    icxz = qmul(icx, z);
    icyz = qmul(icy, z);
    for (int k = 0; k < 16; k++) m[k] = '0;
    m[0] = qadd(qadd(x2, cy2), cz2);
    m[1] = qsub(icxy, zs);
    m[2] = qadd(icxz, ys);
    m[4] = qadd(icxy, zs);
    m[5] = qadd(qadd(cx2, y2), cz2);
    m[6] = qsub(icyz, xs);
    m[8] = qsub(icxz, ys);
    m[9] = qadd(icyz, xs);
    m[10] = qadd(qadd(cx2, cy2), z2);
    m[15] = ONE_Q;
  endtask

  // updates the model matrix, except for unused opcodes, and queues the 16 elements it then holds
  task automatic predict_matrix(input logic [3:0] op, input logic signed [31:0] x, y, z,
                                input logic signed [18:0] ang);
    logic signed [31:0] opm [16];
    logic signed [31:0] a [16];
    logic signed [31:0] b [16];
    longint acc;
    element_t e;
    if (op == tmc_pkg::OP_IDENTITY) begin
      for (int k = 0; k < 16; k++) model_matrix[k] = (k % 5 == 0) ? ONE_Q : 0;
    end else if (op <= tmc_pkg::OP_BACK_R) begin
      case (op)
        tmc_pkg::OP_SET_T, tmc_pkg::OP_FRONT_T, tmc_pkg::OP_BACK_T: begin
          for (int k = 0; k < 16; k++) opm[k] = (k % 5 == 0) ? ONE_Q : 0;
          opm[12] = x;
          opm[13] = y;
          opm[14] = z;
        end
        tmc_pkg::OP_SET_S, tmc_pkg::OP_FRONT_S, tmc_pkg::OP_BACK_S: begin
          for (int k = 0; k < 16; k++) opm[k] = '0;
          opm[0] = x;
          opm[5] = y;
          opm[10] = z;
          opm[15] = ONE_Q;
        end
        default: build_rotation(x, y, z, ang, opm);
      endcase
      if (op <= tmc_pkg::OP_SET_R) begin
        model_matrix = opm;
      end else begin
        if (op <= tmc_pkg::OP_FRONT_R) begin
          a = model_matrix;
          b = opm;
        end else begin
          a = opm;
          b = model_matrix;
        end
        for (int col = 0; col < 4; col++)
          for (int row = 0; row < 4; row++) begin
            acc = 0;
            for (int k = 0; k < 4; k++)
              acc += (longint'(b[col*4+k]) * longint'(a[k*4+row])) >>> tmc_pkg::FRAC_BITS;
            model_matrix[col*4+row] = clamp32(acc);
          end
      end
    end
    for (int k = 0; k < 16; k++) begin
      e.index = k[3:0];
      e.value = model_matrix[k];
      e.last = (k == 15);
      expected_elements.push_back(e);
    end
  endtask

  // called at a falling edge, returns at a falling edge after the transfer
  task automatic send_item(input logic [3:0] op, input logic signed [31:0] x, y, z,
                           input logic signed [18:0] ang);
    int gap;
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    s_tdata <= {1'b0, ang, z, y, x, op};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_matrix(op, x, y, z, ang);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch on %s: got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    element_t want;
    cycle_count <= cycle_count + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_elements.size() == 0) begin
        report_mismatch("unexpected element, index", m_tdata[3:0], -1);
      end else begin
        want = expected_elements.pop_front();
        if (m_tdata[3:0] !== want.index) report_mismatch("index", m_tdata[3:0], want.index);
        if ($signed(m_tdata[35:4]) !== want.value)
          report_mismatch($sformatf("value of element %0d", want.index),
                          $signed(m_tdata[35:4]), want.value);
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last of element %0d", want.index), m_tlast, want.last);
      end
      elements_checked++;
    end
  end

  always @(negedge clk) begin
    if (cycle_count < hold_until) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic signed [31:0] pick_coord();
    case ($urandom_range(9))
      0: return $urandom;
      1: return ($urandom_range(1)) ? 32'sh7FFFFFFF : 32'sh80000000;
      2, 3: return ($urandom_range(1)) ? ONE_Q : -ONE_Q;
      4: return 0;
      default: return $signed($urandom_range(0, 8 * ONE_Q)) - 4 * ONE_Q;
    endcase
  endfunction

  function automatic logic signed [18:0] pick_angle();
    if ($urandom_range(9) == 0) return 19'($urandom);
    return 19'($signed($urandom_range(0, 411774)) - 205887);
  endfunction

  task automatic test_each_operation();
    send_item(tmc_pkg::OP_IDENTITY, 0, 0, 0, 0);
    send_item(tmc_pkg::OP_SET_T, 3 * ONE_Q, -2 * ONE_Q, ONE_Q / 2, 0);
    send_item(tmc_pkg::OP_FRONT_S, 2 * ONE_Q, ONE_Q, -ONE_Q, 0);
    send_item(tmc_pkg::OP_BACK_T, ONE_Q, ONE_Q, ONE_Q, 0);
    send_item(tmc_pkg::OP_BACK_S, ONE_Q / 4, 3 * ONE_Q, ONE_Q, 0);
    send_item(tmc_pkg::OP_SET_R, 0, 0, ONE_Q, 102944);
    send_item(tmc_pkg::OP_FRONT_R, ONE_Q, 0, 0, -51472);
    send_item(tmc_pkg::OP_BACK_R, 0, ONE_Q, 0, 205887);
    send_item(tmc_pkg::OP_FRONT_T, -ONE_Q, 5 * ONE_Q, 0, 0);
    send_item(tmc_pkg::OP_SET_S, ONE_Q, 2 * ONE_Q, 3 * ONE_Q, 0);
    // unused opcodes keep the matrix
    send_item(4'd10, 32'sh12345678, 0, 0, 0);
    send_item(4'd15, -1, -1, -1, -1);
  endtask

  task automatic test_saturation_and_angles();
    send_item(tmc_pkg::OP_SET_S, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 0);
    send_item(tmc_pkg::OP_FRONT_S, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0);
    send_item(tmc_pkg::OP_BACK_T, 32'sh80000000, 32'sh7FFFFFFF, -1, 0);
    // axis far from unit length
    send_item(tmc_pkg::OP_SET_R, 32'sh7FFFFFFF, 32'sh80000000, 7 * ONE_Q, 30000);
    send_item(tmc_pkg::OP_SET_R, ONE_Q, 0, 0, -205887);
    send_item(tmc_pkg::OP_SET_R, 0, ONE_Q, 0, 0);
    // angles beyond plus or minus pi and just below zero
    send_item(tmc_pkg::OP_SET_R, 0, 0, ONE_Q, 19'sh3FFFF);
    send_item(tmc_pkg::OP_SET_R, 0, 0, ONE_Q, 19'sh40000);
    send_item(tmc_pkg::OP_FRONT_R, 0, ONE_Q, 0, 19'sh7FFFF);
    send_item(tmc_pkg::OP_IDENTITY, -1, -1, -1, 19'sh7FFFF);
  endtask

  task automatic test_random_sequences(input int count);
    logic [3:0] op;
    for (int n = 0; n < count; n++) begin
      // restart chains now and then so values stay away from saturation
      if (n % 12 == 0)
        op = ($urandom_range(1)) ? tmc_pkg::OP_IDENTITY : 4'($urandom_range(1, 3));
      else if ($urandom_range(19) == 0) op = 4'($urandom_range(10, 15));
      else op = 4'($urandom_range(0, 9));
      send_item(op, pick_coord(), pick_coord(), pick_coord(), pick_angle());
    end
  endtask

  task automatic test_output_stall();
    hold_until = cycle_count + HOLD_CYCLES;
    for (int n = 0; n < 8; n++)
      send_item(4'($urandom_range(4, 9)), pick_coord(), pick_coord(), pick_coord(), pick_angle());
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    for (int k = 0; k < 16; k++) model_matrix[k] = (k % 5 == 0) ? ONE_Q : 0;
    send_idle_pct = 23;
    recv_idle_pct = 59;
    test_each_operation();
    test_saturation_and_angles();
    test_random_sequences(100);
    send_idle_pct = 59;
    recv_idle_pct = 23;
    test_output_stall();
    test_random_sequences(110);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_sequences(100);
    s_tvalid <= 1'b0;
    while (expected_elements.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("covered %0d items over all opcodes, %0d elements checked", items_sent,
             elements_checked);
    $display("saturation, unused opcodes, wide angles and a long output stall included");
    if (mismatch_count == 0 && expected_elements.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
